FILE: hw/rtl/htd_pkg.sv
`timescale 1ns / 1ps

package htd_pkg;

    localparam int F_BITS          = 4;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int MAX_ITER        = 24;
    localparam int NUM_CELLS       = (CORDIC_ITERATIONS < MAX_ITER) ? CORDIC_ITERATIONS : MAX_ITER;
    localparam int IDX_W           = $clog2(MAX_ITER);

    localparam int TX_W            = 16;
    localparam int RX_W            = 20;
    localparam int D_W             = ((TX_W + F_BITS > RX_W) ? TX_W + F_BITS : RX_W) + 1;
    localparam int PRE_SHIFT       = 24;
    localparam int XY_W            = D_W + PRE_SHIFT + 3;
    localparam int SUM_W           = 2 * D_W;

    localparam int ANG_FRAC        = 16;
    localparam int ANGLE_ONE       = 1 << ANG_FRAC;
    localparam int Z_W             = ANG_FRAC + 11;
    localparam int DEG_W           = Z_W - ANG_FRAC;
    localparam int DEG90           = 90 * ANGLE_ONE;
    localparam int DEG180          = 180 * ANGLE_ONE;
    localparam int DEG360          = 360;

    localparam int HEAD_W          = 8;
    localparam int CM_W            = 7;
    localparam longint DIV         = longint'(10) << F_BITS;
    localparam longint DIV_SQ      = DIV * DIV;
    localparam longint SAT_THRESH  = DIV_SQ * (longint'(1) << (2 * CM_W));

    localparam int S_FIELDS_W      = 2 * TX_W + 2 * RX_W;
    localparam int S_TDATA_W       = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W      = HEAD_W + CM_W + 1;
    localparam int M_TDATA_W       = ((M_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [SUM_W-1:0]       sum;
        logic [CM_W-1:0]        cm;
        logic                   sat;
    } cell_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [IDX_W-1:0] i);
        logic signed [Z_W-1:0] r;
        unique case (i)
            5'd0:    r = Z_W'(2949120);
            5'd1:    r = Z_W'(1740967);
            5'd2:    r = Z_W'(919879);
            5'd3:    r = Z_W'(466945);
            5'd4:    r = Z_W'(234379);
            5'd5:    r = Z_W'(117304);
            5'd6:    r = Z_W'(58666);
            5'd7:    r = Z_W'(29335);
            5'd8:    r = Z_W'(14668);
            5'd9:    r = Z_W'(7334);
            5'd10:   r = Z_W'(3667);
            5'd11:   r = Z_W'(1833);
            5'd12:   r = Z_W'(917);
            5'd13:   r = Z_W'(458);
            5'd14:   r = Z_W'(229);
            5'd15:   r = Z_W'(115);
            5'd16:   r = Z_W'(57);
            5'd17:   r = Z_W'(29);
            5'd18:   r = Z_W'(14);
            5'd19:   r = Z_W'(7);
            5'd20:   r = Z_W'(4);
            5'd21:   r = Z_W'(2);
            5'd22:   r = Z_W'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

    // squared distance at which the cm count reaches c
    function automatic logic [SUM_W-1:0] cm_thresh(input logic [CM_W-1:0] c);
        logic [SUM_W-1:0] sq;
        sq = SUM_W'(c) * SUM_W'(c);
        return SUM_W'(DIV_SQ) * sq;
    endfunction

endpackage

FILE: hw/rtl/htd_prep.sv
`timescale 1ns / 1ps

module htd_prep (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [htd_pkg::TX_W-1:0]   tx,
    input  logic signed [htd_pkg::TX_W-1:0]   ty,
    input  logic signed [htd_pkg::RX_W-1:0]   rx,
    input  logic signed [htd_pkg::RX_W-1:0]   ry,
    output logic                              out_valid,
    input  logic                              out_ready,
    output htd_pkg::cell_t                    out_data
);
    import htd_pkg::*;

    // stage 1: difference vector
    logic                    v1_reg;
    logic signed [D_W-1:0]   dx_reg, dy_reg, dx_next, dy_next;
    // stage 2: squares, CORDIC start vector
    logic                    v2_reg;
    logic [SUM_W-1:0]        sqx_reg, sqy_reg, sqx_next, sqy_next;
    cell_t                   c2_reg, c2_next;
    // stage 3: sum and saturation
    logic                    v3_reg;
    cell_t                   c3_reg, c3_next;

    logic                    adv1, adv2, adv3;
    logic signed [SUM_W-1:0] dxe, dye;
    logic signed [XY_W-1:0]  xe, ye;

    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_comb begin
        dx_next = (D_W'(tx) <<< F_BITS) - D_W'(rx);
        dy_next = (D_W'(ty) <<< F_BITS) - D_W'(ry);
    end

    always_comb begin
        dxe      = SUM_W'(dx_reg);
        dye      = SUM_W'(dy_reg);
        sqx_next = dxe * dxe;
        sqy_next = dye * dye;
        xe       = XY_W'(dx_reg) <<< PRE_SHIFT;
        ye       = XY_W'(dy_reg) <<< PRE_SHIFT;
        c2_next      = '0;
        c2_next.x    = xe;
        c2_next.y    = ye;
        // axis cases get an exact angle and a zero y so no cell rotates
        if (dy_reg == '0) begin
            c2_next.y = '0;
            if (dx_reg[D_W-1]) begin
                c2_next.x = -xe;
                c2_next.z = Z_W'(DEG180);
            end
        end else if (dx_reg == '0) begin
            c2_next.y = '0;
            c2_next.z = dy_reg[D_W-1] ? -Z_W'(DEG90) : Z_W'(DEG90);
        end else if (dx_reg[D_W-1]) begin
            c2_next.x = -xe;
            c2_next.y = -ye;
            c2_next.z = dy_reg[D_W-1] ? -Z_W'(DEG180) : Z_W'(DEG180);
        end
    end

    always_comb begin
        c3_next     = c2_reg;
        c3_next.sum = sqx_reg + sqy_reg;
        c3_next.sat = (c3_next.sum >= SUM_W'(SAT_THRESH));
        c3_next.cm  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && in_valid) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (adv2 && v1_reg) begin
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            c2_reg  <= c2_next;
        end
        if (adv3 && v2_reg) begin
            c3_reg <= c3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = c3_reg;

endmodule

FILE: hw/rtl/htd_cell.sv
`timescale 1ns / 1ps

module htd_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [htd_pkg::IDX_W-1:0]  idx,
    input  logic [htd_pkg::CM_W-1:0]   cm_bit,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  htd_pkg::cell_t             in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output htd_pkg::cell_t             out_data
);
    import htd_pkg::*;

    logic                   v_reg;
    cell_t                  d_reg, d_next;
    logic                   adv;
    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  ang;
    logic [CM_W-1:0]        cand;

    assign adv      = !v_reg || out_ready;
    assign in_ready = adv;

    always_comb begin
        d_next = in_data;
        xs     = in_data.x >>> idx;
        ys     = in_data.y >>> idx;
        ang    = atan_q16(idx);
        cand   = in_data.cm | cm_bit;
        // rotate toward y = 0, hold when y is zero
        if (in_data.y[XY_W-1]) begin
            d_next.x = in_data.x - ys;
            d_next.y = in_data.y + xs;
            d_next.z = in_data.z - ang;
        end else if (in_data.y != '0) begin
            d_next.x = in_data.x + ys;
            d_next.y = in_data.y - xs;
            d_next.z = in_data.z + ang;
        end
        // one bit of the cm count per cell that is given a cm_bit, MSB first
        if (cm_bit != '0 && in_data.sum >= cm_thresh(cand)) begin
            d_next.cm = cand;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (adv) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && in_valid) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

FILE: hw/rtl/htd_out.sv
`timescale 1ns / 1ps

module htd_out (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  htd_pkg::cell_t             in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [htd_pkg::HEAD_W-1:0] heading,
    output logic [htd_pkg::CM_W-1:0]   cm,
    output logic                       sat
);
    import htd_pkg::*;

    logic                    v_reg;
    logic [HEAD_W-1:0]       head_reg, head_next;
    logic [CM_W-1:0]         cm_reg;
    logic                    sat_reg;
    logic                    adv;
    logic signed [Z_W-1:0]   zt;
    logic signed [DEG_W-1:0] deg, degw;

    assign adv      = !v_reg || out_ready;
    assign in_ready = adv;

    always_comb begin
        // degrees truncated toward zero, negative wrapped, then halved
        zt        = in_data.z + (in_data.z[Z_W-1] ? Z_W'(ANGLE_ONE - 1) : Z_W'(0));
        deg       = zt[Z_W-1:ANG_FRAC];
        degw      = deg[DEG_W-1] ? deg + DEG_W'(DEG360) : deg;
        head_next = degw[HEAD_W:1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (adv) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && in_valid) begin
            head_reg <= head_next;
            cm_reg   <= in_data.cm;
            sat_reg  <= in_data.sat;
        end
    end

    assign out_valid = v_reg;
    assign heading   = head_reg;
    assign cm        = cm_reg;
    assign sat       = sat_reg;

endmodule

FILE: hw/rtl/heading_and_distance_to_target.sv
`timescale 1ns / 1ps

// Heading and distance from a robot position to a target position. Takes one
// request per clock while the result side does not stall, and returns one
// result per request, in order: three front stages (difference, squares,
// sum) feed a row of 16 CORDIC vectoring cells, one rotation per cell,
// followed by one output register. The first seven cells also settle one bit
// each of the centimeter count by comparing the squared distance with a
// threshold. Each stage holds one request, so the block keeps accepting while
// a finished result waits, until all 20 stages are full. Heading is in
// two-degree units, 0..179; distance saturates at 127 cm with the flag set.
module heading_and_distance_to_target (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // target_x, target_y, robot_x, robot_y
    input  logic [htd_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // heading_half_degrees, distance_cm, distance_saturated
    output logic [htd_pkg::M_TDATA_W-1:0]    m_tdata
);
    import htd_pkg::*;

    logic signed [TX_W-1:0] target_x, target_y;
    logic signed [RX_W-1:0] robot_x, robot_y;
    logic [NUM_CELLS:0]     ch_valid, ch_ready;
    cell_t                  ch_data [NUM_CELLS+1];
    logic [CM_W-1:0]        cm_mask [NUM_CELLS];
    logic [HEAD_W-1:0]      heading_half_degrees;
    logic [CM_W-1:0]        distance_cm;
    logic                   distance_saturated;

    assign target_x = s_tdata[TX_W-1:0];
    assign target_y = s_tdata[2*TX_W-1:TX_W];
    assign robot_x  = s_tdata[2*TX_W+RX_W-1:2*TX_W];
    assign robot_y  = s_tdata[2*TX_W+2*RX_W-1:2*TX_W+RX_W];

    htd_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .tx        (target_x),
        .ty        (target_y),
        .rx        (robot_x),
        .ry        (robot_y),
        .out_valid (ch_valid[0]),
        .out_ready (ch_ready[0]),
        .out_data  (ch_data[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        if (i < CM_W) begin : g_cm
            assign cm_mask[i] = CM_W'(1) << (CM_W - 1 - i);
        end else begin : g_nocm
            assign cm_mask[i] = '0;
        end

        htd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .idx       (IDX_W'(i)),
            .cm_bit    (cm_mask[i]),
            .in_valid  (ch_valid[i]),
            .in_ready  (ch_ready[i]),
            .in_data   (ch_data[i]),
            .out_valid (ch_valid[i+1]),
            .out_ready (ch_ready[i+1]),
            .out_data  (ch_data[i+1])
        );
    end

    htd_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ch_valid[NUM_CELLS]),
        .in_ready  (ch_ready[NUM_CELLS]),
        .in_data   (ch_data[NUM_CELLS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .heading   (heading_half_degrees),
        .cm        (distance_cm),
        .sat       (distance_saturated)
    );

    assign m_tdata = M_TDATA_W'({distance_saturated, distance_cm, heading_half_degrees});

endmodule

FILE: sim/heading_fix_checker.sv
`timescale 1ns / 1ps

module heading_fix_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [htd_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [htd_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            mismatches,
    output int                            outstanding
);
    import htd_pkg::*;

    localparam int ROTATIONS = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;
    localparam longint DEG_Q16 = 65536;
    localparam longint CM_UNIT = longint'(10) << F_BITS;

    // atan(2^-i) in 2^-16 degree
    localparam longint ARCTAN_Q16 [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic [HEAD_W-1:0] heading;
        logic [CM_W-1:0]   cm;
        logic              sat;
    } fix_t;

    fix_t pending_fixes[$];
    fix_t want;
    fix_t got;

    // angle of (dx, dy) in 2^-16 degree, about (-180, 180]
    function automatic longint vector_angle(input longint dx, input longint dy);
        longint x, y, z, xs, ys;
        int i;
        if (dy == 0) begin
            return (dx < 0) ? 180 * DEG_Q16 : 0;
        end
        if (dx == 0) begin
            return (dy > 0) ? 90 * DEG_Q16 : -90 * DEG_Q16;
        end
        x = dx <<< 24;
        y = dy <<< 24;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? 180 * DEG_Q16 : -180 * DEG_Q16;
            x = -x;
            y = -y;
        end
        for (i = 0; i < ROTATIONS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN_Q16[i];
            end else if (y < 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN_Q16[i];
            end
        end
        return z;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned root, probe;
        root = 0;
        probe = longint'(1) << 62;
        while (probe > n) probe = probe >> 2;
        while (probe != 0) begin
            if (n >= root + probe) begin
                n = n - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic fix_t compute_fix(input logic [S_TDATA_W-1:0] req);
        longint tx, ty, rx, ry, dx, dy, deg;
        longint unsigned range_cm;
        fix_t f;
        tx = longint'($signed(req[15:0]));
        ty = longint'($signed(req[31:16]));
        rx = longint'($signed(req[51:32]));
        ry = longint'($signed(req[71:52]));
        dx = (tx <<< F_BITS) - rx;
        dy = (ty <<< F_BITS) - ry;
        deg = vector_angle(dx, dy) / DEG_Q16;
        if (deg < 0) begin
            deg = deg + 360;
        end
        f.heading = HEAD_W'(deg / 2);
        range_cm = floor_sqrt(longint'(dx * dx + dy * dy)) / CM_UNIT;
        if (range_cm > 127) begin
            f.cm = 7'd127;
            f.sat = 1'b1;
        end else begin
            f.cm = CM_W'(range_cm);
            f.sat = 1'b0;
        end
        return f;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = fix_t'(m_tdata[M_FIELDS_W-1:0]);
                got.heading = m_tdata[7:0];
                got.cm = m_tdata[14:8];
                got.sat = m_tdata[15];
                if (pending_fixes.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: result with no request outstanding: tdata %h",
                                 $realtime, m_tdata);
                    end
                    mismatches++;
                end else begin
                    want = pending_fixes.pop_front();
                    if (got.heading !== want.heading || got.cm !== want.cm ||
                        got.sat !== want.sat) begin
                        if (mismatches < 10) begin
                            $display({"%0t: heading exp %0d got %0d, ",
                                      "cm exp %0d got %0d, sat exp %0d got %0d"},
                                     $realtime, want.heading, got.heading,
                                     want.cm, got.cm, want.sat, got.sat);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pending_fixes.push_back(compute_fix(s_tdata));
            end
            outstanding = pending_fixes.size();
        end
    end

endmodule

FILE: sim/heading_and_distance_to_target_tb.sv
`timescale 1ns / 1ps

module heading_and_distance_to_target_tb;

    import htd_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    int mismatches;
    int outstanding;
    bit hold_req = 1'b0;
    bit quiet = 1'b0;

    always #1 aclk = ~aclk;

    heading_and_distance_to_target dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    heading_fix_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic logic [S_TDATA_W-1:0] pack_request(input int tx, input int ty,
                                                         input int rx, input int ry);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[15:0] = tx[15:0];
        d[31:16] = ty[15:0];
        d[51:32] = rx[19:0];
        d[71:52] = ry[19:0];
        return d;
    endfunction

    function automatic int clamp_mm(input int v);
        if (v > 32767) begin
            return 32767;
        end else if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    function automatic logic [S_TDATA_W-1:0] random_request();
        int tx, ty, rx, ry, d;
        rx = int'($urandom_range(0, 1048575)) - 524288;
        ry = int'($urandom_range(0, 1048575)) - 524288;
        tx = clamp_mm((rx >>> 4) + int'($urandom_range(0, 2800)) - 1400);
        ty = clamp_mm((ry >>> 4) + int'($urandom_range(0, 2800)) - 1400);
        case ($urandom_range(0, 11))
            4: begin
                // less than two mm apart on each axis
                tx = clamp_mm((rx >>> 4) + int'($urandom_range(0, 2)) - 1);
                ty = clamp_mm((ry >>> 4) + int'($urandom_range(0, 2)) - 1);
            end
            5: begin
                // on an axis, or both
                case ($urandom_range(0, 2))
                    0: rx = tx * 16;
                    1: ry = ty * 16;
                    default: begin
                        rx = tx * 16;
                        ry = ty * 16;
                    end
                endcase
            end
            6: begin
                // just off the negative x axis
                tx = -int'($urandom_range(0, 32768));
                rx = tx * 16 + int'($urandom_range(1000, 500000));
                if (rx > 524287) begin
                    rx = 524287;
                end
                ty = int'($urandom_range(0, 60000)) - 30000;
                ry = ty * 16 + int'($urandom_range(0, 4)) - 2;
            end
            7: begin
                d = int'($urandom_range(0, 2000)) - 1000;
                tx = clamp_mm((rx >>> 4) + d);
                ty = clamp_mm((ry >>> 4) + ($urandom_range(0, 1) ? d : -d));
            end
            8, 9: begin
                tx = int'($urandom_range(0, 65535));
                ty = int'($urandom_range(0, 65535));
            end
            default: ;
        endcase
        return pack_request(tx, ty, rx, ry);
    endfunction

    task automatic send_request(input logic [S_TDATA_W-1:0] req);
        s_tvalid <= 1'b1;
        s_tdata <= req;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic maybe_pause();
        if ($urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
    endtask

    task automatic drain();
        while (outstanding != 0) @(negedge aclk);
    endtask

    // result side: random stalls, one long hold-off, none at the end
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int cycles_run;
        cycles_run = 0;
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles_run++;
        end
        $display("heading_and_distance_to_target_tb failed");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_request(pack_request(0, 0, 0, 0));
        send_request(pack_request(100, -50, 1600, -800));
        send_request(pack_request(500, 0, 0, 0));
        send_request(pack_request(0, 500, 0, 0));
        send_request(pack_request(-500, 0, 0, 0));
        send_request(pack_request(0, -500, 0, 0));
        send_request(pack_request(0, 0, 1, 0));
        send_request(pack_request(-1000, 0, 0, 1));
        send_request(pack_request(-1000, 0, 0, -1));
        send_request(pack_request(-32768, 0, 524287, 1));
        send_request(pack_request(-32768, 0, 524287, -1));
        send_request(pack_request(32767, 32767, -524288, -524288));
        send_request(pack_request(-32768, -32768, 524287, 524287));
        send_request(pack_request(0, 0, -20320, 0));
        send_request(pack_request(0, 0, -20479, 0));
        send_request(pack_request(0, 0, -20480, 0));
        send_request(pack_request(100, 100, 0, 0));
        send_request(pack_request(-100, 100, 0, 0));
        send_request(pack_request(-100, -100, 0, 0));
        send_request(pack_request(100, -100, 0, 0));
        send_request(pack_request(0, 0, -1, -1));
        send_request(pack_request(3, -7, 11, 5));
        s_tvalid <= 1'b0;
        drain();

        for (int n = 0; n < 150; n++) begin
            send_request(random_request());
            maybe_pause();
        end

        // back-to-back requests against a long result hold-off
        hold_req = 1'b1;
        for (int n = 0; n < 80; n++) begin
            send_request(random_request());
        end
        s_tvalid <= 1'b0;
        drain();

        for (int n = 0; n < 160; n++) begin
            send_request(random_request());
            maybe_pause();
        end

        quiet = 1'b1;
        for (int n = 0; n < 60; n++) begin
            send_request(random_request());
        end
        s_tvalid <= 1'b0;
        drain();
        repeat (25) @(negedge aclk);

        if (mismatches == 0) begin
            $display("heading_and_distance_to_target_tb passed");
        end else begin
            $display("heading_and_distance_to_target_tb failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/htd_pkg.sv
hw/rtl/htd_prep.sv
hw/rtl/htd_cell.sv
hw/rtl/htd_out.sv
hw/rtl/heading_and_distance_to_target.sv
sim/heading_fix_checker.sv
sim/heading_and_distance_to_target_tb.sv
